// ----- hdl/sap_pkg.sv -----
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types and constants of the shelf atlas packer.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int BoxW    = 7;
  localparam int PosW    = 12;
  localparam int SlotW   = 10;
  localparam int AtlasW  = 13;
  localparam int GapW    = 4;
  localparam int CurXW   = 13;
  localparam int CurYW   = 14;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgAtlasWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAtlasHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGapPixels   = 2'd2;

  localparam logic [AtlasW-1:0] AtlasWidthRst  = 13'd512;
  localparam logic [AtlasW-1:0] AtlasHeightRst = 13'd512;
  localparam logic [GapW-1:0]   GapRst         = 4'd1;
  localparam logic [CurYW-1:0]  CursorYMax     = 14'd16383;

  typedef struct packed {
    logic [BoxW-1:0] box_width;
    logic [BoxW-1:0] box_height;
  } sap_in_t;

  typedef struct packed {
    logic             placed;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [SlotW-1:0] slot_index;
    logic             slots_full;
  } sap_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic emit;
    logic place;
  } sap_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fit;
    logic fit_y;
    logic reject;
  } sap_sts_t;

endpackage

// ----- hdl/sap_ctrl.sv -----
// ----------------------------------------------------------------------------
// sap_ctrl
// Sequencer: takes a beat, iterates fit check / row advance, issues result.
// ----------------------------------------------------------------------------
module sap_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sap_pkg::sap_sts_t sts_i,
  output sap_pkg::sap_cmd_t cmd_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StCheck = 1'b1;

  logic state_q, state_d;
  logic adv_q, adv_d;
  logic out_valid_q, out_valid_d;
  logic out_free, finish;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign finish      = sts_i.reject || sts_i.fit || (adv_q && !sts_i.fit_y);

  always_comb begin
    state_d     = state_q;
    adv_d       = adv_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          adv_d      = 1'b0;
          state_d    = StCheck;
        end
      end
      StCheck: begin
        if (finish) begin
          if (out_free) begin
            cmd_o.emit  = 1'b1;
            cmd_o.place = sts_i.fit && !sts_i.reject;
            out_valid_d = 1'b1;
            state_d     = StIdle;
          end
        end else begin
          cmd_o.advance = 1'b1;
          adv_d         = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      adv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      adv_q       <= adv_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_starts_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == StCheck) && !adv_q)
    else $error("beat taken but check did not start fresh");

  a_reject_no_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck) && sts_i.reject |-> !cmd_o.advance && !cmd_o.place)
    else $error("rejected box advanced or placed");

  a_advance_retries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |=> (state_q == StCheck) && adv_q)
    else $error("row advance did not lead to a retry");

  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !cmd_o.emit)
    else $error("result overwritten while stalled");
`endif

endmodule

// ----- hdl/sap_dpath.sv -----
// ----------------------------------------------------------------------------
// sap_dpath
// Config registers, cursor / row / slot state, fit compare and result register.
// ----------------------------------------------------------------------------
module sap_dpath #(
  parameter int MAX_SLOTS = 1024,
  parameter int MAX_BOX   = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sap_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sap_pkg::AtlasW-1:0]   cfg_data_i,
  input  sap_pkg::sap_in_t             in_data_i,
  input  sap_pkg::sap_cmd_t            cmd_i,
  output sap_pkg::sap_sts_t            sts_o,
  output sap_pkg::sap_out_t            out_data_o
);

  localparam int SCW = $clog2(MAX_SLOTS + 1);

  logic [sap_pkg::AtlasW-1:0] aw_q, ah_q;
  logic [sap_pkg::GapW-1:0]   gap_q, g;
  logic [sap_pkg::BoxW-1:0]   w_q, h_q, rh_q;
  logic [sap_pkg::CurXW-1:0]  cur_x_q;
  logic [sap_pkg::CurYW-1:0]  cur_y_q, next_y;
  logic [SCW-1:0]             cnt_q, last_slot;
  logic [sap_pkg::CurXW:0]    sum_x;
  logic [sap_pkg::CurYW:0]    sum_y, adv_y;
  logic [SCW:0]               cnt_inc;
  logic [31:0]                slot_wide;
  sap_pkg::sap_out_t          out_q;

  assign g = (gap_q == '0) ? sap_pkg::GapW'(1) : gap_q;

  assign sum_x = {1'b0, cur_x_q} + (sap_pkg::CurXW + 1)'(w_q) + (sap_pkg::CurXW + 1)'(g);
  assign sum_y = {1'b0, cur_y_q} + (sap_pkg::CurYW + 1)'(h_q) + (sap_pkg::CurYW + 1)'(g);
  assign adv_y = {1'b0, cur_y_q} + (sap_pkg::CurYW + 1)'(rh_q) + (sap_pkg::CurYW + 1)'(g);
  assign next_y = (adv_y > (sap_pkg::CurYW + 1)'(sap_pkg::CursorYMax)) ?
                  sap_pkg::CursorYMax : adv_y[sap_pkg::CurYW-1:0];

  assign sts_o.fit    = (sum_x < (sap_pkg::CurXW + 1)'(aw_q)) && sts_o.fit_y;
  assign sts_o.fit_y  = sum_y < (sap_pkg::CurYW + 1)'(ah_q);
  assign sts_o.reject = (32'(w_q) > 32'(MAX_BOX)) || (32'(h_q) > 32'(MAX_BOX)) ||
                        (32'(cnt_q) >= 32'(MAX_SLOTS));

  assign cnt_inc   = {1'b0, cnt_q} + (SCW + 1)'(1);
  assign last_slot = (cnt_q == '0) ? '0 : cnt_q - SCW'(1);
  assign slot_wide = cmd_i.place ? 32'(cnt_q) : 32'(last_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q    <= sap_pkg::AtlasWidthRst;
      ah_q    <= sap_pkg::AtlasHeightRst;
      gap_q   <= sap_pkg::GapRst;
      cur_x_q <= sap_pkg::CurXW'(1);
      cur_y_q <= sap_pkg::CurYW'(1);
      rh_q    <= '0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          sap_pkg::CfgAtlasWidth:  aw_q  <= cfg_data_i;
          sap_pkg::CfgAtlasHeight: ah_q  <= cfg_data_i;
          sap_pkg::CfgGapPixels:   gap_q <= cfg_data_i[sap_pkg::GapW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.advance) begin
        cur_x_q <= sap_pkg::CurXW'(g);
        cur_y_q <= next_y;
        rh_q    <= '0;
      end else if (cmd_i.emit && cmd_i.place) begin
        cur_x_q <= sum_x[sap_pkg::CurXW-1:0];
        cnt_q   <= cnt_inc[SCW-1:0];
        if (rh_q < h_q) begin
          rh_q <= h_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= in_data_i.box_width;
      h_q <= in_data_i.box_height;
    end
    if (cmd_i.emit) begin
      out_q.placed     <= cmd_i.place;
      out_q.pos_x      <= cmd_i.place ? cur_x_q[sap_pkg::PosW-1:0] : '0;
      out_q.pos_y      <= cmd_i.place ? cur_y_q[sap_pkg::PosW-1:0] : '0;
      out_q.slot_index <= slot_wide[sap_pkg::SlotW-1:0];
      out_q.slots_full <= cmd_i.place ? (cnt_inc >= (SCW + 1)'(MAX_SLOTS)) :
                                        (32'(cnt_q) >= 32'(MAX_SLOTS));
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- hdl/shelf_atlas_packer_unit.sv -----
// ----------------------------------------------------------------------------
// shelf_atlas_packer_unit
// Shelf packer: places boxes row by row into a fixed atlas, one result a box.
// ----------------------------------------------------------------------------
// Input channel carries a box (width, height); output channel returns
// placed flag, position, slot index and a slots-full flag, one beat per box.
// A beat moves when valid is high and stall is low. Config writes go over
// the cfg channel (index 0 width, 1 height, 2 gap), always ready; write only
// while idle.
// Flow: each box is captured whether or not it fits, then checked and its
// result registered; its result shows the cycle after that check.
// Each row advance is followed by a new fit check at the moved cursor. A box
// too wide for any row keeps stepping down by the gap until it no longer
// fits below the atlas height.
// Reset: cursor at (1,1), empty row, no slots used, atlas 512x512, gap 1.
// Stall: the result is held in the output register; one further box can be
// taken and is held in its check step until that register frees.
// ----------------------------------------------------------------------------
module shelf_atlas_packer_unit #(
  parameter int MAX_SLOTS = 1024,
  parameter int MAX_BOX   = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  sap_pkg::sap_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sap_pkg::sap_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [sap_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sap_pkg::AtlasW-1:0]  cfg_data_i
);

  sap_pkg::sap_cmd_t cmd;
  sap_pkg::sap_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sap_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .MAX_BOX   (MAX_BOX)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/tb_shelf_atlas_packer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shelf_atlas_packer_unit
// Self-checking bench for the shelf atlas packer.
// ----------------------------------------------------------------------------
// Each box is run through a shelf-packing model when it is queued, which
// gives the result expected for it. A negedge driver sends the boxes with
// random gaps. A posedge monitor checks every result beat, field by field,
// against the oldest expected result. The run steps through atlas settings,
// among them empty and tiny atlases and the widest one. Under each setting,
// boxes are queued until a set count is reached or the cursor has moved far
// enough. A last phase of tiny boxes uses up every slot.
// ----------------------------------------------------------------------------
module tb_shelf_atlas_packer_unit;

  localparam int Period      = 8;
  localparam int ResetCycles = 7;
  localparam int MaxSlots    = 1024;
  localparam int MaxBox      = 64;
  localparam int AtlasMax    = 8191;
  localparam int YRoom       = 500;
  localparam int SettleCycles = 10;
  localparam int HoldStart   = 60;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 1000000;
  localparam int MaxReports  = 40;
  localparam int ItemTarget  = 1800;

  localparam logic [sap_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef enum int {MixNormal, MixWide, MixTiny} box_mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sap_pkg::sap_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sap_pkg::sap_out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [sap_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [sap_pkg::AtlasW-1:0] cfg_data_i;

  shelf_atlas_packer_unit #(
    .MAX_SLOTS(MaxSlots),
    .MAX_BOX  (MaxBox)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(Period / 2) clk_i = ~clk_i;

  // packer model: configuration and state
  logic [sap_pkg::AtlasW-1:0] atlas_w_cfg = sap_pkg::AtlasWidthRst;
  logic [sap_pkg::AtlasW-1:0] atlas_h_cfg = sap_pkg::AtlasHeightRst;
  logic [sap_pkg::GapW-1:0]   gap_cfg     = sap_pkg::GapRst;
  logic [sap_pkg::CurXW-1:0]  cur_x       = 13'd1;
  logic [sap_pkg::CurYW-1:0]  cur_y       = 14'd1;
  logic [sap_pkg::BoxW-1:0]   shelf_h     = '0;
  logic [10:0]                slots_used  = '0;

  sap_pkg::sap_in_t  box_q[$];
  sap_pkg::sap_out_t result_q[$];

  bit calm = 1'b0;
  bit in_took = 1'b0;
  bit cfg_took = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int send_gap = 0;
  int recv_wait = 0;
  int in_beats = 0;
  int out_beats = 0;
  int placed_seen = 0;
  int refused_seen = 0;
  int full_seen = 0;
  int settings = 1;
  int queued = 0;
  int fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  sap_pkg::sap_out_t want;

  sap_pkg::sap_in_t corner_boxes [22] = '{
    {7'd0, 7'd0}, {7'd64, 7'd64}, {7'd64, 7'd0}, {7'd0, 7'd64}, {7'd1, 7'd1},
    {7'd63, 7'd63}, {7'd65, 7'd1}, {7'd1, 7'd65}, {7'd127, 7'd127},
    {7'd127, 7'd0}, {7'd0, 7'd127}, {7'd64, 7'd65}, {7'd65, 7'd64},
    {7'd85, 7'd42}, {7'd42, 7'd85}, {7'd32, 7'd32}, {7'd64, 7'd1},
    {7'd1, 7'd64}, {7'd21, 7'd42}, {7'd42, 7'd21}, {7'd0, 7'd0}, {7'd64, 7'd64}
  };

  // Place one box on the shelves; updates the model state.
  task automatic shelve_box(input sap_pkg::sap_in_t box, output sap_pkg::sap_out_t res);
    int w, h, g, nxt_y;
    bit done;
    w = box.box_width;
    h = box.box_height;
    g = (gap_cfg == '0) ? 1 : int'(gap_cfg);
    res = '0;
    done = 1'b0;
    if (w > MaxBox || h > MaxBox || slots_used >= MaxSlots) done = 1'b1;
    while (!done) begin
      if (cur_x + w + g < atlas_w_cfg && cur_y + h + g < atlas_h_cfg) begin
        res.placed = 1'b1;
        res.pos_x = sap_pkg::PosW'(cur_x);
        res.pos_y = sap_pkg::PosW'(cur_y);
        res.slot_index = sap_pkg::SlotW'(slots_used);
        slots_used = slots_used + 1'b1;
        cur_x = sap_pkg::CurXW'(cur_x + w + g);
        if (shelf_h < h) shelf_h = sap_pkg::BoxW'(h);
        done = 1'b1;
      end else begin
        cur_x = sap_pkg::CurXW'(g);
        nxt_y = cur_y + shelf_h + g;
        cur_y = (nxt_y > sap_pkg::CursorYMax) ? sap_pkg::CursorYMax :
                                                sap_pkg::CurYW'(nxt_y);
        shelf_h = '0;
        if (!(cur_y + h + g < atlas_h_cfg)) done = 1'b1;
      end
    end
    if (!res.placed)
      res.slot_index = (slots_used != 0) ? sap_pkg::SlotW'(slots_used - 1) : '0;
    res.slots_full = (slots_used >= MaxSlots);
  endtask

  function automatic sap_pkg::sap_in_t pick_box(input box_mix_e mix);
    sap_pkg::sap_in_t b;
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MixTiny: begin
        b.box_width  = sap_pkg::BoxW'($urandom_range(0, 4));
        b.box_height = sap_pkg::BoxW'($urandom_range(0, 4));
      end
      MixWide: begin
        b.box_width  = sap_pkg::BoxW'($urandom_range(40, MaxBox));
        b.box_height = sap_pkg::BoxW'($urandom_range(0, 16));
      end
      default: begin
        if (r < 10) begin
          b = sap_pkg::sap_in_t'(14'($urandom_range(0, 16383)));
        end else if (r < 18) begin
          b.box_width  = $urandom_range(0, 1) ? sap_pkg::BoxW'(MaxBox) : '0;
          b.box_height = $urandom_range(0, 1) ? sap_pkg::BoxW'(MaxBox) : '0;
        end else begin
          b.box_width  = sap_pkg::BoxW'($urandom_range(0, MaxBox));
          b.box_height = sap_pkg::BoxW'($urandom_range(0, MaxBox));
        end
      end
    endcase
    return b;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rel_height();
    int h;
    h = cur_y + $urandom_range(150, 450);
    return (h > AtlasMax) ? AtlasMax : h;
  endfunction

  task automatic queue_box(input sap_pkg::sap_in_t box);
    sap_pkg::sap_out_t res;
    shelve_box(box, res);
    box_q.push_back(box);
    result_q.push_back(res);
    queued++;
  endtask

  // Queue boxes until the count is reached or the cursor has gone far enough.
  task automatic queue_boxes(input int count, input box_mix_e mix);
    int stop_y;
    stop_y = cur_y + YRoom;
    for (int n = 0; n < count && cur_y <= stop_y; n++) queue_box(pick_box(mix));
  endtask

  task automatic drain();
    while (result_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [sap_pkg::CfgIdxW-1:0] idx,
                           input logic [sap_pkg::AtlasW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (!cfg_took);
    cfg_valid_i <= 1'b0;
    case (idx)
      sap_pkg::CfgAtlasWidth:  atlas_w_cfg = val;
      sap_pkg::CfgAtlasHeight: atlas_h_cfg = val;
      sap_pkg::CfgGapPixels:   gap_cfg = val[sap_pkg::GapW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_atlas(input int w, input int h, input int g);
    drain();
    calm = ($urandom_range(0, 3) == 0);
    write_reg(sap_pkg::CfgAtlasWidth, sap_pkg::AtlasW'(w));
    write_reg(sap_pkg::CfgAtlasHeight, sap_pkg::AtlasW'(h));
    write_reg(sap_pkg::CfgGapPixels,
              sap_pkg::AtlasW'({$urandom_range(0, 511), sap_pkg::GapW'(g)}));
    settings++;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fail_cnt++;
      if (fail_cnt <= MaxReports)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  // box driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      // stalled beat holds
    end else if (send_gap != 0) begin
      in_valid_i <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (box_q.size() != 0) begin
      in_data_i  <= box_q.pop_front();
      in_valid_i <= 1'b1;
      send_gap   <= idle_len();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // result receiver stall
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
    end else if (recv_wait != 0) begin
      out_stall_i <= 1'b1;
      recv_wait <= recv_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
      recv_wait <= idle_len();
    end
  end

  // long receiver hold-off, once
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_beats >= HoldStart) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_took  <= in_valid_i && !in_stall_o;
    cfg_took <= cfg_valid_i && cfg_ready_o;
    if (in_valid_i && !in_stall_o) in_beats <= in_beats + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      out_beats <= out_beats + 1;
      if (result_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MaxReports)
          $display("%0t: result beat with none expected, expected nothing, got %h",
                   $time, out_data_o);
      end else begin
        want = result_q.pop_front();
        check_field("placed", want.placed, out_data_o.placed);
        check_field("pos_x", want.pos_x, out_data_o.pos_x);
        check_field("pos_y", want.pos_y, out_data_o.pos_y);
        check_field("slot_index", want.slot_index, out_data_o.slot_index);
        check_field("slots_full", want.slots_full, out_data_o.slots_full);
        if (want.placed) placed_seen++;
        else refused_seen++;
        if (want.slots_full) full_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout, %0d results still expected", $time, result_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = sap_pkg::CfgAtlasWidth;
    cfg_data_i = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: corner boxes, then random fill of the 512x512 atlas
    foreach (corner_boxes[i]) queue_box(corner_boxes[i]);
    queue_boxes(130, MixNormal);

    set_atlas(300, rel_height(), 0);
    queue_boxes(150, MixNormal);
    set_atlas(0, rel_height(), 3);
    write_reg(CfgSpare, sap_pkg::AtlasW'($urandom_range(0, AtlasMax)));
    queue_boxes(12, MixNormal);
    set_atlas(1, 0, 15);
    queue_boxes(12, MixNormal);
    set_atlas(4096, 4096, 15);
    queue_boxes(150, MixNormal);
    set_atlas(64, rel_height(), 2);
    queue_boxes(60, MixNormal);
    set_atlas(AtlasMax, rel_height(), 7);
    queue_boxes(150, MixWide);
    set_atlas(1000, 1, 1);
    queue_boxes(10, MixNormal);
    set_atlas(1, rel_height(), 5);
    queue_boxes(10, MixNormal);
    repeat (4) begin
      set_atlas($urandom_range(64, 4096), rel_height(), $urandom_range(0, 15));
      queue_boxes(200, MixNormal);
    end

    // use up every slot, then check refusals once full
    set_atlas(AtlasMax, AtlasMax, 1);
    for (int n = 0; n < 3000 && slots_used < MaxSlots && cur_y + 8 < AtlasMax; n++)
      queue_box(pick_box(MixTiny));
    queue_boxes((queued < ItemTarget) ? ItemTarget - queued : 30, MixNormal);

    drain();
    $display("Packed %0d boxes under %0d atlas settings: %0d placed, %0d refused,",
             out_beats, settings, placed_seen, refused_seen);
    $display("%0d results with all slots used, %0d mismatches", full_seen, fail_cnt);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
